// ----- rtl/core/gha_pkg.sv -----
// ============================================================================
// Generational handle allocator package
// Operation and status codes, default sizing and stream field layout.
// ============================================================================
package gha_pkg;

    // Default table sizing handed to the top level parameters.
    localparam int GHA_SLOTS    = 256;
    localparam int GHA_GEN_BITS = 16;

    // Stream payload field widths.
    localparam int OP_W     = 2;
    localparam int HIDX_W   = 8;
    localparam int HGEN_W   = 16;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 32;

    // Operation codes. The unused code behaves as a check.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CHECK = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_STALE   = 2'd1,
        ST_UNALLOC = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

// ----- rtl/core/gha_ram.sv -----
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered, read-first.
// ============================================================================
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/generational_handle_allocator.sv -----
// A result passes through the operand register, which takes the RAM reads,
// and then the result register.
// Throughput: one operation per cycle while m_tready does not hold the result;
// stack and generation RAM writes are forwarded to the following operation's read.
// Reset: counters and valid flags clear at once; the RAMs, which also hold the
// live flags, are not cleared and no clearing pass runs, so input starts at once.
// ============================================================================
// Generational handle allocator
// Hands out slot index plus generation handles from a fixed slot table, with
// a LIFO stack of freed slots, and frees or checks handles.
// ============================================================================
module generational_handle_allocator
    import gha_pkg::*;
#(
    parameter int SLOTS    = GHA_SLOTS,
    parameter int GEN_BITS = GHA_GEN_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // op [1:0], handle_index [9:2], handle_generation [25:10], zero [31:26]
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // status [1:0], result_index [9:2], result_generation [25:10], zero [31:26]
    output logic [TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int CW    = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;
    localparam int GW    = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;
    localparam int SE_W  = IDX_W + GEN_BITS;
    localparam int GE_W  = GEN_BITS + 1;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_fire, exec_fire;

    assign exec_fire = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || exec_fire;
    assign in_fire   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] fc_reg, fc_next;
    logic [CNT_W-1:0] su_reg, su_next;

    // Operand register
    logic [OP_W-1:0]     s1_op_reg;
    logic [HIDX_W-1:0]   s1_hidx_reg;
    logic [HGEN_W-1:0]   s1_hgen_reg;
    logic                s1_gbyp_reg, s1_gbyp_next;
    logic [GE_W-1:0]     s1_gbyp_data_reg;
    logic                s1_sbyp_reg, s1_sbyp_next;
    logic [SE_W-1:0]     s1_sbyp_data_reg;

    // Result register
    logic [STATUS_W-1:0] out_status_reg;
    logic [HIDX_W-1:0]   out_index_reg;
    logic [HGEN_W-1:0]   out_gen_reg;

    // ------------------------------------------------------------------
    // RAMs
    // ------------------------------------------------------------------
    logic                gen_we;
    logic [IDX_W-1:0]    gen_waddr;
    logic [GE_W-1:0]     gen_wdata;
    logic [IDX_W-1:0]    gen_raddr;
    logic [GE_W-1:0]     gen_q;
    logic                stk_we;
    logic [IDX_W-1:0]    stk_waddr;
    logic [SE_W-1:0]     stk_wdata;
    logic [IDX_W-1:0]    stk_raddr;
    logic [SE_W-1:0]     stk_q;

    // Each generation entry carries the slot's live flag in its top bit.
    gha_ram #(
        .WIDTH (GE_W),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .clk   (clk),
        .we    (exec_fire && gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (in_fire),
        .raddr (gen_raddr),
        .rdata (gen_q)
    );

    // Each stack entry keeps the slot's generation beside its index, so a
    // pop needs no second read of the generation table.
    gha_ram #(
        .WIDTH (SE_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (exec_fire && stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (in_fire),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    // ------------------------------------------------------------------
    // Read addresses for the incoming operation
    // ------------------------------------------------------------------
    logic [CW-1:0]    in_idx_ext;
    logic [CNT_W-1:0] fc_eff;
    logic [CNT_W-1:0] fc_m1;

    assign in_idx_ext = CW'(s_tdata[9:2]);
    assign gen_raddr  = in_idx_ext[IDX_W-1:0];
    // The pop address must see the count left by the operation executing now.
    assign fc_eff     = exec_fire ? fc_next : fc_reg;
    assign fc_m1      = fc_eff - 1'b1;
    assign stk_raddr  = fc_m1[IDX_W-1:0];

    assign s1_gbyp_next = exec_fire && gen_we && (gen_waddr == gen_raddr);
    assign s1_sbyp_next = exec_fire && stk_we && (stk_waddr == stk_raddr);

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    logic [CW-1:0]       s1_idx_ext;
    logic [IDX_W-1:0]    s1_idx;
    logic [GE_W-1:0]     gen_rd;
    logic                cur_live;
    logic [GEN_BITS-1:0] cur_gen;
    logic [GEN_BITS-1:0] gen_inc;
    logic [SE_W-1:0]     stk_rd;
    logic [IDX_W-1:0]    stk_idx;
    logic [GEN_BITS-1:0] stk_gen;
    status_t             res_status;
    logic [CW-1:0]       res_index_ext;
    logic [GW-1:0]       res_gen_ext;

    assign s1_idx_ext = CW'(s1_hidx_reg);
    assign s1_idx     = s1_idx_ext[IDX_W-1:0];
    assign gen_rd     = s1_gbyp_reg ? s1_gbyp_data_reg : gen_q;
    assign cur_live   = gen_rd[GEN_BITS];
    assign cur_gen    = gen_rd[GEN_BITS-1:0];
    assign gen_inc    = cur_gen + 1'b1;
    assign stk_rd     = s1_sbyp_reg ? s1_sbyp_data_reg : stk_q;
    assign stk_idx    = stk_rd[SE_W-1:GEN_BITS];
    assign stk_gen    = stk_rd[GEN_BITS-1:0];

    always_comb
    begin
        fc_next       = fc_reg;
        su_next       = su_reg;
        gen_we        = 1'b0;
        gen_waddr     = s1_idx;
        gen_wdata     = '0;
        stk_we        = 1'b0;
        stk_waddr     = fc_reg[IDX_W-1:0];
        stk_wdata     = {s1_idx, gen_inc};
        res_status    = ST_OK;
        res_index_ext = s1_idx_ext;
        res_gen_ext   = '0;

        if (op_t'(s1_op_reg) == OP_ALLOC)
        begin
            priority if (fc_reg != '0)
            begin
                fc_next       = fc_reg - 1'b1;
                gen_we        = 1'b1;
                gen_waddr     = stk_idx;
                gen_wdata     = {1'b1, stk_gen};
                res_index_ext = CW'(stk_idx);
                res_gen_ext   = GW'(stk_gen);
            end
            else if (su_reg < CNT_W'(SLOTS))
            begin
                su_next       = su_reg + 1'b1;
                gen_we        = 1'b1;
                gen_waddr     = su_reg[IDX_W-1:0];
                gen_wdata     = {1'b1, {GEN_BITS{1'b0}}};
                res_index_ext = CW'(su_reg);
            end
            else
            begin
                res_status    = ST_FULL;
                res_index_ext = '0;
            end
        end
        else if (s1_idx_ext >= CW'(su_reg))
        begin
            res_status = ST_UNALLOC;
        end
        else if (!cur_live || (GW'(cur_gen) != GW'(s1_hgen_reg)))
        begin
            res_status  = ST_STALE;
            res_gen_ext = GW'(cur_gen);
        end
        else
        begin
            res_gen_ext = GW'(cur_gen);
            if (op_t'(s1_op_reg) == OP_FREE)
            begin
                res_gen_ext = GW'(gen_inc);
                gen_we      = 1'b1;
                gen_wdata   = {1'b0, gen_inc};
                if (fc_reg < CNT_W'(SLOTS))
                begin
                    stk_we  = 1'b1;
                    fc_next = fc_reg + 1'b1;
                end
            end
        end
    end

    assign s1_valid_next  = in_fire || (s1_valid_reg && !exec_fire);
    assign out_valid_next = exec_fire || (out_valid_reg && !m_tready);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fc_reg        <= '0;
            su_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                fc_reg <= fc_next;
                su_reg <= su_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg        <= s_tdata[1:0];
            s1_hidx_reg      <= s_tdata[9:2];
            s1_hgen_reg      <= s_tdata[25:10];
            s1_gbyp_reg      <= s1_gbyp_next;
            s1_gbyp_data_reg <= gen_wdata;
            s1_sbyp_reg      <= s1_sbyp_next;
            s1_sbyp_data_reg <= stk_wdata;
        end
        if (exec_fire)
        begin
            out_status_reg <= res_status;
            out_index_reg  <= res_index_ext[HIDX_W-1:0];
            out_gen_reg    <= res_gen_ext[HGEN_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_gen_reg, out_index_reg, out_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fc_le_su : assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= su_reg)
        else $error("free stack holds more entries than slots ever used");

    a_su_bound : assert property (@(posedge clk) disable iff (!rst_n)
        su_reg <= CNT_W'(SLOTS))
        else $error("high-water mark beyond table size");

    a_full_only_when_exhausted : assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && (res_status == ST_FULL)) |->
            ((fc_reg == '0) && (su_reg == CNT_W'(SLOTS))))
        else $error("table full reported while a slot is available");

    a_result_follows_exec : assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> m_tvalid)
        else $error("executed operation did not reach the result register");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Generational handle allocator testbench
// Streams allocate, free and check operations into the allocator and checks
// every response against a cycle-free model of the slot table, the LIFO free
// stack and the per-slot generations. Both stream sides idle at random.
// ============================================================================
module tb;
    import gha_pkg::*;

    // The fourth operation code is not named in the package; it acts as a check.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int PAD_W = TDATA_W - OP_W - HIDX_W - HGEN_W;
    localparam int RANDOM_OPS = 2000;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [HGEN_W-1:0] gen;
        logic [HIDX_W-1:0] idx;
        logic [OP_W-1:0]   op;
    } handle_request_t;

    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [HGEN_W-1:0] gen;
        logic [HIDX_W-1:0] idx;
        status_t           status;
    } handle_response_t;

    typedef enum int {
        PHASE_GROW,
        PHASE_DRAIN,
        PHASE_MIXED,
        PHASE_FILL
    } phase_kind_t;

    class slot_table_tracker;
        logic [HGEN_W-1:0] generation [GHA_SLOTS];
        logic [HIDX_W-1:0] free_stack [GHA_SLOTS];
        bit                live [GHA_SLOTS];
        int unsigned       free_depth;
        int unsigned       used_count;
        handle_response_t  awaited [$];
        int                mismatch_count;
        int                response_count;
        int                op_count [4];
        int                status_count [4];

        function new();
            free_depth = 0;
            used_count = 0;
            mismatch_count = 0;
            response_count = 0;
            foreach (live[i]) live[i] = 1'b0;
            foreach (op_count[i]) op_count[i] = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        function bit table_full();
            return used_count == GHA_SLOTS && free_depth == 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Applies one operation to the slot table and returns its response.
        function handle_response_t resolve_request(input handle_request_t req);
            handle_response_t  rsp;
            logic [HIDX_W-1:0] slot;
            logic [HGEN_W-1:0] cur;
            rsp = '0;
            if (req.op == OP_ALLOC)
            begin
                if (free_depth > 0)
                begin
                    free_depth--;
                    slot = free_stack[free_depth];
                end
                else if (used_count < GHA_SLOTS)
                begin
                    slot = used_count[HIDX_W-1:0];
                    used_count++;
                    generation[slot] = '0;
                end
                else
                begin
                    rsp.status = ST_FULL;
                    return rsp;
                end
                live[slot] = 1'b1;
                rsp.status = ST_OK;
                rsp.idx = slot;
                rsp.gen = generation[slot];
                return rsp;
            end
            rsp.idx = req.idx;
            if (req.idx >= used_count)
            begin
                rsp.status = ST_UNALLOC;
                return rsp;
            end
            cur = generation[req.idx];
            if (!live[req.idx] || cur != req.gen)
            begin
                rsp.status = ST_STALE;
                rsp.gen = cur;
                return rsp;
            end
            if (req.op == OP_FREE)
            begin
                cur = cur + 1'b1;
                generation[req.idx] = cur;
                live[req.idx] = 1'b0;
                free_stack[free_depth] = req.idx;
                free_depth++;
            end
            rsp.status = ST_OK;
            rsp.gen = cur;
            return rsp;
        endfunction

        function void note_request(input handle_request_t req);
            handle_response_t rsp;
            op_count[req.op]++;
            rsp = resolve_request(req);
            awaited = {awaited, rsp};
        endfunction

        task report_mismatch(input string what);
            mismatch_count++;
            $display("[%0t] response %0d: %s", $realtime, response_count, what);
        endtask

        task check_response(input logic [TDATA_W-1:0] word);
            handle_response_t got;
            handle_response_t want;
            got = word;
            response_count++;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("response %h with no operation waiting", word));
                return;
            end
            want = awaited.pop_front();
            status_count[want.status]++;
            if (got.status != want.status)
                report_mismatch($sformatf("status %s, expected %s",
                                          got.status.name(), want.status.name()));
            if (got.idx != want.idx)
                report_mismatch($sformatf("index %0d, expected %0d", got.idx, want.idx));
            if (got.gen != want.gen)
                report_mismatch($sformatf("generation %0d, expected %0d", got.gen, want.gen));
            if (got.pad != '0)
                report_mismatch($sformatf("padding bits %h are not zero", got.pad));
        endtask

        function bit pick_live(output logic [HIDX_W-1:0] idx,
                               output logic [HGEN_W-1:0] gen);
            int candidates [$];
            for (int i = 0; i < used_count; i++)
                if (live[i]) candidates = {candidates, i};
            if (candidates.size() == 0) return 1'b0;
            idx = HIDX_W'(candidates[$urandom_range(candidates.size() - 1)]);
            gen = generation[idx];
            return 1'b1;
        endfunction

        // A slot that was handed out before and is now on the free stack.
        function bit pick_retired(output logic [HIDX_W-1:0] idx,
                                  output logic [HGEN_W-1:0] gen);
            int candidates [$];
            for (int i = 0; i < used_count; i++)
                if (!live[i]) candidates = {candidates, i};
            if (candidates.size() == 0) return 1'b0;
            idx = HIDX_W'(candidates[$urandom_range(candidates.size() - 1)]);
            gen = generation[idx];
            return 1'b1;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;

    slot_table_tracker tracker = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int phase_count = 0;

    generational_handle_allocator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Sends one operation, idling between bursts, and records it once transferred.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [HIDX_W-1:0] idx,
                           input logic [HGEN_W-1:0] gen);
        handle_request_t req;
        int              gap;
        req = '0;
        req.op = op;
        req.idx = idx;
        req.gen = gen;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
            gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = req;
        forever
        begin
            @(posedge clk);
            if (s_tready) break;
        end
        tracker.note_request(req);
    endtask

    // Mostly well-formed traffic: frees and checks aim at live handles, with
    // some wrong generations, retired slots and fully random handles mixed in.
    task automatic send_random_op(input int alloc_pct, input int free_pct);
        logic [OP_W-1:0]   op;
        logic [HIDX_W-1:0] idx;
        logic [HGEN_W-1:0] gen;
        int                roll;
        int                kind;
        roll = $urandom_range(99);
        kind = $urandom_range(99);
        idx = HIDX_W'($urandom);
        gen = HGEN_W'($urandom);
        if (roll < alloc_pct)
            op = OP_ALLOC;
        else if (roll < alloc_pct + free_pct)
            op = OP_FREE;
        else
            op = ($urandom_range(3) == 0) ? OP_SPARE : OP_CHECK;
        if (op != OP_ALLOC)
        begin
            if (kind < 70 && tracker.pick_live(idx, gen))
                ;
            else if (kind < 82 && tracker.pick_live(idx, gen))
                gen = gen ^ (16'h1 << $urandom_range(HGEN_W - 1));
            else if (kind < 92 && tracker.pick_retired(idx, gen))
                ;
            else
            begin
                idx = HIDX_W'($urandom);
                gen = HGEN_W'($urandom);
            end
        end
        send_op(op, idx, gen);
    endtask

    // The receiver switches at random between four stall patterns.
    int rx_mode = 0;
    int rx_left = 0;
    int rx_phase = 0;
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(3);
            rx_left = $urandom_range(16, 200);
        end
        rx_left = rx_left - 1;
        rx_phase = rx_phase + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(1));
            2: m_tready <= (rx_phase % 5) < 2;
            default: m_tready <= ($urandom_range(15) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_response(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, tracker.pending());
            $display("generational_handle_allocator test failed");
            $finish;
        end
    end

    initial
    begin
        phase_kind_t phase;
        int          sent;
        int          length;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, first allocations, stale and double frees,
        // LIFO reuse, the spare code and the high-water boundary.
        send_op(OP_CHECK, 8'd0, 16'd0);
        send_op(OP_FREE, 8'd255, 16'hFFFF);
        send_op(OP_ALLOC, 8'd0, 16'd0);
        send_op(OP_ALLOC, 8'hFF, 16'hFFFF);
        send_op(OP_ALLOC, 8'd0, 16'd0);
        send_op(OP_CHECK, 8'd1, 16'd0);
        send_op(OP_CHECK, 8'd1, 16'h8000);
        send_op(OP_SPARE, 8'd2, 16'd0);
        send_op(OP_FREE, 8'd1, 16'd0);
        send_op(OP_FREE, 8'd1, 16'd1);
        send_op(OP_CHECK, 8'd1, 16'd1);
        send_op(OP_FREE, 8'd2, 16'd0);
        send_op(OP_ALLOC, 8'd0, 16'd0);
        send_op(OP_ALLOC, 8'd0, 16'd0);
        send_op(OP_ALLOC, 8'd0, 16'd0);
        send_op(OP_CHECK, 8'd4, 16'd0);
        send_op(OP_FREE, 8'd0, 16'hFFFF);
        send_op(OP_SPARE, 8'd200, 16'h5A5A);
        send_op(OP_FREE, 8'd0, 16'd0);
        send_op(OP_CHECK, 8'd3, 16'h0001);

        sent = 0;
        while (sent < RANDOM_OPS)
        begin
            phase_count++;
            if (phase_count % 6 == 3)
                phase = PHASE_FILL;
            else
                phase = phase_kind_t'($urandom_range(2));
            length = $urandom_range(40, 160);
            case (phase)
                PHASE_FILL:
                begin
                    // Run the table out of slots, then hit it while full.
                    while (!tracker.table_full())
                    begin
                        send_random_op(90, 0);
                        sent++;
                    end
                    repeat (4)
                    begin
                        send_op(OP_ALLOC, HIDX_W'($urandom), HGEN_W'($urandom));
                        sent++;
                    end
                end
                PHASE_GROW:
                    repeat (length)
                    begin
                        send_random_op(60, 25);
                        sent++;
                    end
                PHASE_DRAIN:
                    repeat (length)
                    begin
                        send_random_op(15, 65);
                        sent++;
                    end
                default:
                    repeat (length)
                    begin
                        send_random_op(35, 35);
                        sent++;
                    end
            endcase
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Ran %0d allocates, %0d frees, %0d checks and %0d spare-code checks",
                 tracker.op_count[OP_ALLOC], tracker.op_count[OP_FREE],
                 tracker.op_count[OP_CHECK], tracker.op_count[OP_SPARE]);
        $display("over %0d phases; responses: %0d ok, %0d stale, %0d never allocated,",
                 phase_count, tracker.status_count[ST_OK],
                 tracker.status_count[ST_STALE], tracker.status_count[ST_UNALLOC]);
        $display("%0d table full; %0d mismatches.",
                 tracker.status_count[ST_FULL], tracker.mismatch_count);
        if (tracker.mismatch_count == 0)
            $display("generational_handle_allocator test passed");
        else
            $display("generational_handle_allocator test failed");
        $finish;
    end

endmodule
